### rtl/mnps_pkg.sv
// Shared constants, codes and controller/datapath interface types for the note stack.
package mnps_pkg;

  // Field widths
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int OP_W     = 2;
  localparam int ACTION_W = 2;
  localparam int S_DATA_W = 16;  // note, velocity, zero fill
  localparam int M_DATA_W = 24;  // target_note, out_velocity, glide, latch_hold, gate_set, fill
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // Default stack depth
  localparam int MNPS_NOTE_SLOTS = 10;

  // Event codes
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  // Voice command codes
  localparam logic [ACTION_W-1:0] ACT_RETRIG   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SLIDE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GATE_OFF = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEARED  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEGATO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLIDE  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // load the accepted request
    logic exec;     // update the stack and load the result register
  } mnps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_nop;    // incoming request carries an undefined event code
    logic out_free;  // result register can take a new result this cycle
  } mnps_status_t;

endpackage

### rtl/mnps_ctrl.sv
// Controller: sequences capture and execute of one event at a time.
module mnps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  mnps_pkg::mnps_status_t status,
  output mnps_pkg::mnps_cmd_t    cmd
);
  import mnps_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        // undefined event codes are taken and dropped
        if (s_tvalid && !status.in_nop) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

endmodule

### rtl/mnps_datapath.sv
// Datapath: note stack, compare-and-shift update, config and result registers.
module mnps_datapath #(
  parameter int NOTE_SLOTS = mnps_pkg::MNPS_NOTE_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mnps_pkg::OP_W-1:0]       s_tuser,
  input  logic [mnps_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mnps_pkg::ACTION_W-1:0]   m_tuser,
  output logic [mnps_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [mnps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mnps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mnps_pkg::mnps_cmd_t             cmd,
  output mnps_pkg::mnps_status_t          status
);
  import mnps_pkg::*;

  localparam int CNT_W = $clog2(NOTE_SLOTS + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(NOTE_SLOTS);

  // Entry 0 holds the most recent note; entries at count and above are stale
  logic [NOTE_W-1:0] stack [NOTE_SLOTS];
  logic [CNT_W-1:0]  count;

  logic legato_mode;
  logic latch_mode;
  logic glide_enable;

  logic [OP_W-1:0]   op_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;

  logic [NOTE_SLOTS-1:0] hit;
  logic [NOTE_SLOTS-1:0] shift_sel;
  logic                  found;
  logic                  had;
  logic [NOTE_W-1:0]     removed    [NOTE_SLOTS];
  logic [NOTE_W-1:0]     stack_next [NOTE_SLOTS];
  logic [CNT_W-1:0]      count_rm;
  logic [CNT_W-1:0]      count_next;

  logic [ACTION_W-1:0] res_action;
  logic [NOTE_W-1:0]   res_note;
  logic [VEL_W-1:0]    res_vel;
  logic                res_glide;
  logic                res_latch;
  logic                res_gate;

  logic [ACTION_W-1:0] out_action;
  logic [NOTE_W-1:0]   out_note;
  logic [VEL_W-1:0]    out_vel;
  logic                out_glide;
  logic                out_latch;
  logic                out_gate;

  // Status toward the controller
  assign status.in_nop   = (s_tuser != OP_NOTE_ON) && (s_tuser != OP_NOTE_OFF) &&
                           (s_tuser != OP_CLEAR);
  assign status.out_free = !m_tvalid || m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      legato_mode  <= 1'b0;
      latch_mode   <= 1'b0;
      glide_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEGATO: legato_mode  <= cfg_data[0];
        CFG_LATCH:  latch_mode   <= cfg_data[0];
        CFG_GLIDE:  glide_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= s_tuser;
      note_q <= s_tdata[NOTE_W-1:0];
      vel_q  <= s_tdata[NOTE_W+VEL_W-1:NOTE_W];
    end
  end

  // Compare every held entry; shift_sel marks the matching entry and all older ones
  always_comb begin
    for (int k = 0; k < NOTE_SLOTS; k++) begin
      hit[k] = (CNT_W'(k) < count) && (stack[k] == note_q);
    end
    shift_sel[0] = hit[0];
    for (int k = 1; k < NOTE_SLOTS; k++) begin
      shift_sel[k] = shift_sel[k-1] | hit[k];
    end
  end

  assign found    = shift_sel[NOTE_SLOTS-1];
  assign had      = (count != '0);
  assign count_rm = count - CNT_W'(found);

  // Close the gap left by the removed note
  always_comb begin
    for (int k = 0; k < NOTE_SLOTS - 1; k++) begin
      removed[k] = shift_sel[k] ? stack[k+1] : stack[k];
    end
    removed[NOTE_SLOTS-1] = stack[NOTE_SLOTS-1];
  end

  // Next stack contents and result
  always_comb begin
    for (int k = 0; k < NOTE_SLOTS; k++) begin
      stack_next[k] = removed[k];
    end
    count_next = count;
    res_action = ACT_CLEARED;
    res_note   = '0;
    res_vel    = '0;
    res_glide  = 1'b0;
    res_latch  = 1'b0;
    res_gate   = 1'b0;
    case (op_q)
      OP_NOTE_ON: begin
        // push on top; the oldest entry falls off the end when full
        stack_next[0] = note_q;
        for (int k = 1; k < NOTE_SLOTS; k++) begin
          stack_next[k] = removed[k-1];
        end
        count_next = (count_rm == DEPTH_CNT) ? count_rm : count_rm + 1'b1;
        res_note   = note_q;
        res_latch  = latch_mode;
        res_gate   = 1'b1;
        if (legato_mode && had) begin
          res_action = ACT_SLIDE;
          res_glide  = glide_enable;
        end else begin
          res_action = ACT_RETRIG;
          res_vel    = vel_q;
          res_glide  = glide_enable && had;
        end
      end
      OP_NOTE_OFF: begin
        count_next = count_rm;
        if (count_rm != '0) begin
          res_action = ACT_SLIDE;
          res_note   = removed[0];
          res_glide  = glide_enable;
        end else begin
          res_action = ACT_GATE_OFF;
        end
      end
      default: begin
        // clear
        count_next = '0;
      end
    endcase
  end

  // Stack storage, no reset: stale entries are never read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < NOTE_SLOTS; k++) begin
        stack[k] <= stack_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_action <= res_action;
      out_note   <= res_note;
      out_vel    <= res_vel;
      out_glide  <= res_glide;
      out_latch  <= res_latch;
      out_gate   <= res_gate;
    end
  end

  assign m_tuser = out_action;
  assign m_tdata = {7'b0, out_gate, out_latch, out_glide, out_vel, out_note};

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("held count above stack depth");

  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> status.out_free)
    else $error("result overwritten before it was taken");

  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("executed request produced no result");

  a_note_on_held: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op_q == OP_NOTE_ON) |=> (count != '0))
    else $error("stack empty after note on");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op_q == OP_CLEAR) |=> (count == '0) && (m_tuser == ACT_CLEARED))
    else $error("clear left notes held");
`endif

endmodule

### rtl/mono_note_priority_stack_core.sv
// Top level: last-note priority stack for a monophonic voice.
//
//  Channel  Dir  Handshake            Payload
//  s_*      in   s_tvalid/s_tready    tuser: op; tdata: note, velocity
//  m_*      out  m_tvalid/m_tready    tuser: action; tdata: target_note, out_velocity,
//                                     glide, latch_hold, gate_set
//  cfg_*    in   cfg_we               cfg_index, cfg_data (1 bit)
//
// Each event is handled as a capture of the request, then an execute step for the
// parallel compare of all held notes, the shift and the result register load.
// A request with an undefined event code is taken and dropped.
// A stalled result register holds the execute cycle until m_tready frees it.
// Reset (rst, synchronous) empties the stack and clears the config registers.
module mono_note_priority_stack_core #(
  parameter int NOTE_SLOTS = mnps_pkg::MNPS_NOTE_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mnps_pkg::OP_W-1:0]       s_tuser,   // [1:0] op
  input  logic [mnps_pkg::S_DATA_W-1:0]   s_tdata,   // [6:0] note, [13:7] velocity
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mnps_pkg::ACTION_W-1:0]   m_tuser,   // [1:0] action
  output logic [mnps_pkg::M_DATA_W-1:0]   m_tdata,   // [6:0] target_note,
                                                     // [13:7] out_velocity, [14] glide,
                                                     // [15] latch_hold, [16] gate_set
  input  logic                            cfg_we,
  input  logic [mnps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mnps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mnps_pkg::*;

  mnps_cmd_t    cmd;
  mnps_status_t status;

  mnps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mnps_datapath #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
